// ===== src/two_coil_launch_sequencer_top_assert.svh =====
// Assertion macros used by the sequencer core.
`ifndef TWO_COIL_LAUNCH_SEQUENCER_TOP_ASSERT_SVH
`define TWO_COIL_LAUNCH_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TCLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCLS_ASSERT(label, clk, rst_n, prop, msg)
`define TCLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define TCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/tcls_pkg.sv =====
package tcls_pkg;

  // Fixed field widths of the channels and registers.
  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 10;
  localparam int TMO_W      = 16;
  localparam int GAP_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CHAN_W     = 2;
  localparam int EVENT_W    = 3;
  localparam int PEAK_W     = 10;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] TRIGGER_THRESHOLD_RST = LEVEL_W'(512);
  localparam logic [LEVEL_W-1:0] MIN_DEVIATION_RST     = LEVEL_W'(180);
  localparam logic [LEVEL_W-1:0] FALL_MARGIN_RST       = LEVEL_W'(2);
  localparam logic [TMO_W-1:0]   COIL0_TIMEOUT_RST     = TMO_W'(800);
  localparam logic [TMO_W-1:0]   COIL1_TIMEOUT_RST     = TMO_W'(200);
  localparam logic [GAP_W-1:0]   GAP_RST               = GAP_W'(2);
  localparam int                 BASELINE_RST          = 511;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_THRESHOLD = 3'd0,
    REG_MIN_DEVIATION     = 3'd1,
    REG_FALL_MARGIN       = 3'd2,
    REG_COIL0_TIMEOUT     = 3'd3,
    REG_COIL1_TIMEOUT     = 3'd4,
    REG_GAP               = 3'd5
  } cfg_reg_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_S1_DONE  = 3'd1,
    EV_S2_DONE  = 3'd2,
    EV_TIMEOUT1 = 3'd3,
    EV_TIMEOUT2 = 3'd4
  } event_e;

  typedef enum logic [CHAN_W-1:0] {
    CH_TRIGGER = 2'd0,
    CH_HALL0   = 2'd1,
    CH_HALL1   = 2'd2
  } chan_e;

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_S1_BASE = 6'b000010,
    PH_S1_RUN  = 6'b000100,
    PH_GAP     = 6'b001000,
    PH_S2_BASE = 6'b010000,
    PH_S2_RUN  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_threshold;
    logic [LEVEL_W-1:0] min_deviation;
    logic [LEVEL_W-1:0] fall_margin;
    logic [TMO_W-1:0]   coil0_timeout_ms;
    logic [TMO_W-1:0]   coil1_timeout_ms;
    logic [GAP_W-1:0]   gap_ms;
  } cfg_t;

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

// ===== src/tcls_if.sv =====
interface tcls_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [tcls_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink (input valid, input mode, input sample, output ready);
endinterface

interface tcls_out_if;
  logic                         valid;
  logic                         ready;
  logic                         coil0_drive;
  logic                         coil1_drive;
  logic [tcls_pkg::CHAN_W-1:0]  channel_select;
  logic                         busy_res;
  logic [tcls_pkg::EVENT_W-1:0] event_res;
  logic [tcls_pkg::PEAK_W-1:0]  peak_value;

  modport source (output valid, output coil0_drive, output coil1_drive,
                  output channel_select, output busy_res, output event_res,
                  output peak_value, input ready);
  modport sink (input valid, input coil0_drive, input coil1_drive,
                input channel_select, input busy_res, input event_res,
                input peak_value, output ready);
endinterface

interface tcls_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcls_pkg::CFG_IDX_W-1:0]  index;
  logic [tcls_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/two_coil_launch_sequencer_top.sv =====
// Two-coil launch sequencer. Each input word is either an ADC sample (mode 0) taken on
// the channel named by the last result, or a one millisecond tick (mode 1), and each
// word yields exactly one result word that shows the coil drives, the next channel,
// the busy flag, an event code and the stage peak. A word enters an input register,
// and the whole sequencing step then runs from it into the result register, so
// one word is taken every clock while results are taken; the result register is the
// only thing that can hold up the input, and only while its word is not taken.
// Registers are written through the configuration channel, which is always ready,
// and must only be written while the block is idle.
module two_coil_launch_sequencer_top #(
  parameter int SAMPLE_BITS       = 10,
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcls_in_if.sink    in_i,
  tcls_out_if.source out_o,
  tcls_cfg_if.sink   cfg_i
);
  import tcls_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;

  tcls_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tcls_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  tcls_core #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (item_valid),
    .item_i    (item),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// ===== src/tcls_cfg_regs.sv =====
module tcls_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  tcls_cfg_if.sink       cfg_i,
  output tcls_pkg::cfg_t cfg_o
);
  import tcls_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_threshold <= TRIGGER_THRESHOLD_RST;
      cfg_q.min_deviation     <= MIN_DEVIATION_RST;
      cfg_q.fall_margin       <= FALL_MARGIN_RST;
      cfg_q.coil0_timeout_ms  <= COIL0_TIMEOUT_RST;
      cfg_q.coil1_timeout_ms  <= COIL1_TIMEOUT_RST;
      cfg_q.gap_ms            <= GAP_RST;
    end else if (cfg_i.valid) begin
      // Writes to indexes past the register list are dropped.
      case (cfg_i.index)
        REG_TRIGGER_THRESHOLD: cfg_q.trigger_threshold <= cfg_i.data[LEVEL_W-1:0];
        REG_MIN_DEVIATION:     cfg_q.min_deviation     <= cfg_i.data[LEVEL_W-1:0];
        REG_FALL_MARGIN:       cfg_q.fall_margin       <= cfg_i.data[LEVEL_W-1:0];
        REG_COIL0_TIMEOUT:     cfg_q.coil0_timeout_ms  <= cfg_i.data[TMO_W-1:0];
        REG_COIL1_TIMEOUT:     cfg_q.coil1_timeout_ms  <= cfg_i.data[TMO_W-1:0];
        REG_GAP:               cfg_q.gap_ms            <= cfg_i.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tcls_in_stage.sv =====
module tcls_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  tcls_in_if.sink         in_i,
  input  logic            advance_i,
  output logic            valid_o,
  output tcls_pkg::item_t item_o
);
  import tcls_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The slot frees up in the same cycle the core takes the held word.
  assign in_i.ready = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.mode   <= in_i.mode;
      item_q.sample <= in_i.sample;
    end
  end

endmodule

// ===== src/tcls_core.sv =====
`include "two_coil_launch_sequencer_top_assert.svh"

module tcls_core #(
  parameter int SAMPLE_BITS       = 10,
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcls_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  tcls_pkg::item_t item_i,
  output logic            advance_o,
  tcls_out_if.source      out_o
);
  import tcls_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int TB = TICK_COUNTER_BITS;
  // Compare width CW holds either operand plus one carry bit; EW holds either operand.
  localparam int CW = ((SB > LEVEL_W) ? SB : LEVEL_W) + 1;
  localparam int EW = (TB > TMO_W) ? TB : TMO_W;
  localparam logic [SB-1:0] BASE_RESET = SB'(BASELINE_RST);

  phase_e        phase_q, phase_d;
  logic [SB-1:0] base_q, base_d;
  logic [SB-1:0] peak_q, peak_d;
  logic [TB-1:0] elap_q, elap_d;
  event_e        event_d;

  logic          out_vq;
  logic          coil0_q, coil1_q, busy_q;
  chan_e         chan_q, chan_d;
  event_e        event_q;
  logic [PEAK_W-1:0] peakv_q;
  logic          coil0_d, coil1_d, busy_d;

  logic          is_tick;
  logic [SB-1:0] samp;
  logic [SB-1:0] dev;
  logic [SB-1:0] peak_new;
  logic [CW-1:0] dev_x;
  logic          stage_end;
  logic          trig_hit;
  logic [TB-1:0] tick_sat;
  logic          over_t0, over_t1, gap_done;
  logic [31:0]   peak_wide;

  assign advance_o = valid_i && (!out_vq || out_o.ready);

  assign is_tick = item_i.mode;
  assign samp    = SB'(32'(item_i.sample));

  // Deviation tracking for the running stage.
  assign dev       = (samp > base_q) ? (samp - base_q) : (base_q - samp);
  assign peak_new  = (dev > peak_q) ? dev : peak_q;
  assign dev_x     = CW'(dev);
  assign stage_end = (dev_x > CW'(cfg_i.min_deviation)) &&
                     ((dev_x + CW'(cfg_i.fall_margin)) < CW'(peak_new));
  assign trig_hit  = !is_tick && (CW'(samp) > CW'(cfg_i.trigger_threshold));

  assign tick_sat = (elap_q == {TB{1'b1}}) ? elap_q : elap_q + TB'(1);
  assign over_t0  = EW'(tick_sat) > EW'(cfg_i.coil0_timeout_ms);
  assign over_t1  = EW'(tick_sat) > EW'(cfg_i.coil1_timeout_ms);
  assign gap_done = EW'(tick_sat) >= EW'(cfg_i.gap_ms);

  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    peak_d  = peak_q;
    elap_d  = elap_q;
    event_d = EV_NONE;
    case (phase_q)
      PH_S1_BASE, PH_S2_BASE: begin
        if (is_tick) begin
          elap_d = tick_sat;
          if (phase_q == PH_S1_BASE && over_t0) begin
            event_d = EV_TIMEOUT1;
            phase_d = PH_WAIT;
          end else if (phase_q == PH_S2_BASE && over_t1) begin
            event_d = EV_TIMEOUT2;
            phase_d = PH_WAIT;
          end
        end else begin
          base_d  = samp;
          peak_d  = '0;
          elap_d  = '0;
          phase_d = (phase_q == PH_S1_BASE) ? PH_S1_RUN : PH_S2_RUN;
        end
      end
      PH_S1_RUN: begin
        if (is_tick) begin
          elap_d = tick_sat;
          if (over_t0) begin
            event_d = EV_TIMEOUT1;
            phase_d = PH_WAIT;
          end
        end else begin
          peak_d = peak_new;
          if (stage_end) begin
            event_d = EV_S1_DONE;
            elap_d  = '0;
            phase_d = (cfg_i.gap_ms == '0) ? PH_S2_BASE : PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (is_tick) begin
          elap_d = tick_sat;
          if (gap_done) begin
            elap_d  = '0;
            phase_d = PH_S2_BASE;
          end
        end
      end
      PH_S2_RUN: begin
        if (is_tick) begin
          elap_d = tick_sat;
          if (over_t1) begin
            event_d = EV_TIMEOUT2;
            phase_d = PH_WAIT;
          end
        end else begin
          peak_d = peak_new;
          if (stage_end) begin
            event_d = EV_S2_DONE;
            phase_d = PH_WAIT;
          end
        end
      end
      default: begin
        // Waiting, and any code that should never appear, behave alike.
        phase_d = PH_WAIT;
        if (trig_hit) begin
          phase_d = PH_S1_BASE;
          elap_d  = '0;
        end
      end
    endcase
  end

  // The result word shows the state after this step.
  always_comb begin
    coil0_d = 1'b0;
    coil1_d = 1'b0;
    busy_d  = 1'b1;
    case (phase_d)
      PH_S1_BASE: chan_d = CH_HALL0;
      PH_S1_RUN: begin
        chan_d  = CH_HALL0;
        coil0_d = 1'b1;
      end
      PH_GAP, PH_S2_BASE: chan_d = CH_HALL1;
      PH_S2_RUN: begin
        chan_d  = CH_HALL1;
        coil1_d = 1'b1;
      end
      default: begin
        chan_d = CH_TRIGGER;
        busy_d = 1'b0;
      end
    endcase
  end

  assign peak_wide = 32'(peak_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      base_q  <= BASE_RESET;
      peak_q  <= '0;
      elap_q  <= '0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      peak_q  <= peak_d;
      elap_q  <= elap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (!out_vq || out_o.ready) begin
      out_vq <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      coil0_q <= coil0_d;
      coil1_q <= coil1_d;
      busy_q  <= busy_d;
      chan_q  <= chan_d;
      event_q <= event_d;
      peakv_q <= peak_wide[PEAK_W-1:0];
    end
  end

  assign out_o.valid          = out_vq;
  assign out_o.coil0_drive    = coil0_q;
  assign out_o.coil1_drive    = coil1_q;
  assign out_o.channel_select = chan_q;
  assign out_o.busy_res       = busy_q;
  assign out_o.event_res      = event_q;
  assign out_o.peak_value     = peakv_q;

  `TCLS_ASSERT(a_coils_exclusive, clk_i, rst_ni, !(out_vq && coil0_q && coil1_q), "both coils driven")
  `TCLS_ASSERT_IMPLY(a_coil_busy, clk_i, rst_ni, out_vq && (coil0_q || coil1_q), busy_q, "coil on while idle")
  `TCLS_ASSERT_IMPLY(a_end_idle, clk_i, rst_ni, out_vq && (event_q == EV_S2_DONE || event_q == EV_TIMEOUT1 || event_q == EV_TIMEOUT2), !busy_q && !coil0_q && !coil1_q, "launch end not idle")
  `TCLS_ASSERT_NEXT(a_stall_holds_state, clk_i, rst_ni, out_vq && !out_o.ready, $stable(phase_q) && $stable(elap_q), "state moved under stall")

endmodule
